// ----- rtl/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, codes and types for the controller binding evaluator.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // raw sample width of axis values and binding range ends
  localparam int AXIS_BITS  = 16;
  // standard axis output width and configuration limit widths
  localparam int OUT_BITS   = 16;
  localparam int LOW_BITS   = 16;
  localparam int LIMIT_BITS = 15;
  localparam int CFG_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;

  // differences of two axis values
  localparam int DIFF_BITS  = AXIS_BITS + 1;
  // magnitude of a range difference, also the divisor width
  localparam int MAG_BITS   = AXIS_BITS;
  // magnitude of the output span (out_max - out_min)
  localparam int SPAN_BITS  = OUT_BITS;
  // signed output-side values before saturation
  localparam int RES_BITS   = OUT_BITS + 2;
  // dividend width and quotient width
  localparam int PROD_BITS  = MAG_BITS + SPAN_BITS;
  localparam int QUO_BITS   = SPAN_BITS;

  // divider: quotient bits resolved per pipeline stage
  localparam int Q_PER_STAGE = 2;
  localparam int DIV_STAGES  = (QUO_BITS + Q_PER_STAGE - 1) / Q_PER_STAGE;

  // input and output stream widths
  localparam int IN_TDATA_BITS  = 64;
  localparam int OUT_TDATA_BITS = 24;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_HAT    = 2'd1,
    OP_AXIS   = 2'd2,
    OP_UNUSED = 2'd3
  } cbe_op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_AXIS_LOW  = 2'd0,
    REG_AXIS_HIGH = 2'd1,
    REG_TRIG_HIGH = 2'd2,
    REG_NONE      = 2'd3
  } cbe_reg_t;

  // information that rides along with an item through the divider
  typedef struct packed {
    logic                       use_div;
    logic                       neg_q;
    logic                       pressed;
    logic signed [RES_BITS-1:0] base;
  } cbe_side_t;

endpackage

// ----- rtl/cbe_div.sv -----
// ----------------------------------------------------------------------------
// cbe_div
// Pipelined unsigned restoring divider, a fixed number of quotient bits per
// stage, with a side-band struct that travels beside each item.
// ----------------------------------------------------------------------------
module cbe_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic [cbe_pkg::PROD_BITS-1:0]        num,
  input  logic [cbe_pkg::MAG_BITS-1:0]         den,
  input  cbe_pkg::cbe_side_t                   in_side,
  output logic                                 out_valid,
  output logic [cbe_pkg::QUO_BITS-1:0]         quo,
  output cbe_pkg::cbe_side_t                   out_side
);

  localparam int MB = cbe_pkg::MAG_BITS;
  localparam int QB = cbe_pkg::QUO_BITS;
  localparam int NS = cbe_pkg::DIV_STAGES;

  typedef struct packed {
    logic [MB-1:0] rem;
    logic [QB-1:0] low;
    logic [QB-1:0] quo;
  } div_state_t;

  // a few restoring steps; rem stays below den on entry and exit
  function automatic div_state_t div_steps(div_state_t s, logic [MB-1:0] d);
    div_state_t r;
    logic [MB:0] t;
    r = s;
    for (int i = 0; i < cbe_pkg::Q_PER_STAGE; i++) begin
      t = {r.rem, r.low[QB-1]};
      r.low = {r.low[QB-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t = t - {1'b0, d};
        r.quo = {r.quo[QB-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[QB-2:0], 1'b0};
      end
      r.rem = t[MB-1:0];
    end
    return r;
  endfunction

  logic               v_r    [NS];
  div_state_t         st_r   [NS];
  logic [MB-1:0]      den_r  [NS];
  cbe_pkg::cbe_side_t side_r [NS];

  div_state_t         st_in  [NS];
  div_state_t         st_nxt [NS];

  always_comb begin
    st_in[0].rem = num[cbe_pkg::PROD_BITS-1:QB];
    st_in[0].low = num[QB-1:0];
    st_in[0].quo = '0;
    st_nxt[0]    = div_steps(st_in[0], den);
    for (int k = 1; k < NS; k++) begin
      st_in[k]  = st_r[k-1];
      st_nxt[k] = div_steps(st_in[k], den_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NS; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]   <= st_nxt[0];
      den_r[0]  <= den;
      side_r[0] <= in_side;
      for (int k = 1; k < NS; k++) begin
        st_r[k]   <= st_nxt[k];
        den_r[k]  <= den_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign quo       = st_r[NS-1].quo;
  assign out_side  = side_r[NS-1];

endmodule

// ----- rtl/controller_binding_evaluator.sv -----
// ----------------------------------------------------------------------------
// controller_binding_evaluator
// Evaluates one controller binding against its raw control sample per item.
// ----------------------------------------------------------------------------
// Usage: each in_ transfer carries one binding and the current sample of the
// raw control it names (button, hat or axis). Each out_ transfer returns the
// pressed flag and the rescaled standard axis value, one result per item, in
// order. Limits are to be written on the cfg_ port only while no item is in
// flight; the block itself does not enforce this. Pipeline: 4 front stages for
// range, clamp, magnitude and multiply, 8 divider stages resolving 2 quotient
// bits each, 1 output stage for offset and saturation.
// Throughput: one item per cycle while the output is not stalled; the pipeline
// is fully registered and every stage moves together.
// Reset: all valid bits clear and the limits return to -32768 / 32767 /
// 32767. When the receiver holds out_tready low with a result waiting, the
// whole pipeline freezes and in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module controller_binding_evaluator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // cfg
  input  logic                                   cfg_wr_en,
  input  logic [cbe_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [cbe_pkg::CFG_BITS-1:0]           cfg_wdata,
  // input stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // op[1:0] binding_valid[2] control_present[3] button_level[4]
  // hat_state[8:5] hat_select[12:9] axis_sample[28:13] range_start[44:29]
  // range_end[60:45] out_unipolar[61] out_positive[62] out_negative[63]
  input  logic [cbe_pkg::IN_TDATA_BITS-1:0]      in_tdata,
  // result stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // pressed[0] axis_out[16:1] zero[23:17]
  output logic [cbe_pkg::OUT_TDATA_BITS-1:0]     out_tdata
);

  localparam int AB = cbe_pkg::AXIS_BITS;
  localparam int DB = cbe_pkg::DIFF_BITS;
  localparam int MB = cbe_pkg::MAG_BITS;
  localparam int SB = cbe_pkg::SPAN_BITS;
  localparam int RB = cbe_pkg::RES_BITS;
  localparam int PB = cbe_pkg::PROD_BITS;
  localparam int QB = cbe_pkg::QUO_BITS;
  localparam int OB = cbe_pkg::OUT_BITS;
  localparam int LB = cbe_pkg::LOW_BITS;
  localparam int HB = cbe_pkg::LIMIT_BITS;

  // ---------------------------------------------------------------- config
  logic signed [LB-1:0] axis_low_limit_r;
  logic [HB-1:0]        axis_high_limit_r;
  logic [HB-1:0]        trigger_high_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_low_limit_r     <= {1'b1, {(LB-1){1'b0}}};
      axis_high_limit_r    <= '1;
      trigger_high_limit_r <= '1;
    end else if (cfg_wr_en) begin
      unique case (cbe_pkg::cbe_reg_t'(cfg_index))
        cbe_pkg::REG_AXIS_LOW:  axis_low_limit_r     <= cfg_wdata[LB-1:0];
        cbe_pkg::REG_AXIS_HIGH: axis_high_limit_r    <= cfg_wdata[HB-1:0];
        cbe_pkg::REG_TRIG_HIGH: trigger_high_limit_r <= cfg_wdata[HB-1:0];
        default: ;
      endcase
    end
  end

  logic signed [RB-1:0] low_ext;
  logic signed [RB-1:0] high_ext;
  logic signed [RB-1:0] trig_ext;

  assign low_ext  = RB'(axis_low_limit_r);
  assign high_ext = signed'({{(RB-HB){1'b0}}, axis_high_limit_r});
  assign trig_ext = signed'({{(RB-HB){1'b0}}, trigger_high_limit_r});

  // ------------------------------------------------------------ flow control
  logic adv;
  logic out_valid_r;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------- input unpack
  cbe_pkg::cbe_op_t     in_op;
  logic                 in_bvalid;
  logic                 in_present;
  logic                 in_button;
  logic [3:0]           in_hat_state;
  logic [3:0]           in_hat_select;
  logic signed [AB-1:0] in_sample;
  logic signed [AB-1:0] in_rs;
  logic signed [AB-1:0] in_re;
  logic                 in_uni;
  logic                 in_pos;
  logic                 in_neg;

  assign in_op         = cbe_pkg::cbe_op_t'(in_tdata[1:0]);
  assign in_bvalid     = in_tdata[2];
  assign in_present    = in_tdata[3];
  assign in_button     = in_tdata[4];
  assign in_hat_state  = in_tdata[8:5];
  assign in_hat_select = in_tdata[12:9];
  assign in_sample     = in_tdata[28:13];
  assign in_rs         = in_tdata[44:29];
  assign in_re         = in_tdata[60:45];
  assign in_uni        = in_tdata[61];
  assign in_pos        = in_tdata[62];
  assign in_neg        = in_tdata[63];

  // ------------------------------------------------ stage 1: range and clamp
  logic signed [RB-1:0] s1_omin_nxt;
  logic signed [RB-1:0] s1_omax_nxt;
  logic signed [AB-1:0] lo;
  logic signed [AB-1:0] hi;
  logic                 below;
  logic                 above;
  logic signed [AB-1:0] s1_c_nxt;

  always_comb begin
    priority if (in_neg) begin
      s1_omin_nxt = '0;
      s1_omax_nxt = low_ext;
    end else if (in_pos) begin
      s1_omin_nxt = '0;
      s1_omax_nxt = high_ext;
    end else if (in_uni) begin
      s1_omin_nxt = '0;
      s1_omax_nxt = trig_ext;
    end else begin
      s1_omin_nxt = low_ext;
      s1_omax_nxt = high_ext;
    end
  end

  always_comb begin
    if (in_rs <= in_re) begin
      lo = in_rs;
      hi = in_re;
    end else begin
      lo = in_re;
      hi = in_rs;
    end
    below = in_sample < lo;
    above = in_sample > hi;
    priority if (below) s1_c_nxt = lo;
    else if (above)     s1_c_nxt = hi;
    else                s1_c_nxt = in_sample;
  end

  logic                 s1_v_r;
  cbe_pkg::cbe_op_t     s1_op_r;
  logic                 s1_bvalid_r;
  logic                 s1_present_r;
  logic                 s1_button_r;
  logic                 s1_hat_hit_r;
  logic                 s1_inrange_r;
  logic signed [AB-1:0] s1_rs_r;
  logic signed [AB-1:0] s1_c_r;
  logic signed [DB-1:0] s1_span_r;
  logic signed [RB-1:0] s1_omin_r;
  logic signed [RB-1:0] s1_omax_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r      <= in_op;
      s1_bvalid_r  <= in_bvalid;
      s1_present_r <= in_present;
      s1_button_r  <= in_button;
      s1_hat_hit_r <= |(in_hat_state & in_hat_select);
      s1_inrange_r <= !below && !above;
      s1_rs_r      <= in_rs;
      s1_c_r       <= s1_c_nxt;
      s1_span_r    <= DB'(in_re) - DB'(in_rs);
      s1_omin_r    <= s1_omin_nxt;
      s1_omax_r    <= s1_omax_nxt;
    end
  end

  // ------------------------------------ stage 2: offsets, half span, |span|
  logic                 s2_v_r;
  cbe_pkg::cbe_op_t     s2_op_r;
  logic                 s2_bvalid_r;
  logic                 s2_present_r;
  logic                 s2_button_r;
  logic                 s2_hat_hit_r;
  logic                 s2_inrange_r;
  logic                 s2_span_neg_r;
  logic                 s2_span_zero_r;
  logic [MB-1:0]        s2_abs_span_r;
  logic signed [DB-1:0] s2_d_r;
  logic signed [DB-1:0] s2_half_r;
  logic signed [RB-1:0] s2_dout_r;
  logic signed [RB-1:0] s2_omin_r;
  logic signed [RB-1:0] s2_omax_r;

  logic signed [DB-1:0] span_rnd;
  logic signed [DB-1:0] span_neg_val;

  // half span truncated toward zero
  assign span_rnd     = s1_span_r + DB'({{(DB-1){1'b0}}, s1_span_r[DB-1]});
  assign span_neg_val = -s1_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r        <= s1_op_r;
      s2_bvalid_r    <= s1_bvalid_r;
      s2_present_r   <= s1_present_r;
      s2_button_r    <= s1_button_r;
      s2_hat_hit_r   <= s1_hat_hit_r;
      s2_inrange_r   <= s1_inrange_r;
      s2_span_neg_r  <= s1_span_r[DB-1];
      s2_span_zero_r <= (s1_span_r == '0);
      s2_abs_span_r  <= s1_span_r[DB-1] ? span_neg_val[MB-1:0] : s1_span_r[MB-1:0];
      s2_d_r         <= DB'(s1_c_r) - DB'(s1_rs_r);
      s2_half_r      <= span_rnd >>> 1;
      s2_dout_r      <= s1_omax_r - s1_omin_r;
      s2_omin_r      <= s1_omin_r;
      s2_omax_r      <= s1_omax_r;
    end
  end

  // ---------------------------------- stage 3: pressed, magnitudes, result base
  logic                 pr;
  logic                 axis_pr;
  logic signed [DB-1:0] d_neg;
  logic signed [RB-1:0] dout_neg;
  cbe_pkg::cbe_side_t   s3_side_nxt;

  assign d_neg    = -s2_d_r;
  assign dout_neg = -s2_dout_r;

  always_comb begin
    // within range the clamped offset equals the sample offset from start
    axis_pr = s2_present_r && s2_inrange_r &&
              (s2_span_neg_r ? (s2_d_r <= s2_half_r) : (s2_d_r >= s2_half_r));
    unique case (s2_op_r)
      cbe_pkg::OP_BUTTON: pr = s2_present_r && s2_button_r;
      cbe_pkg::OP_HAT:    pr = s2_present_r && s2_hat_hit_r;
      cbe_pkg::OP_AXIS:   pr = axis_pr;
      default:            pr = 1'b0;
    endcase

    s3_side_nxt.use_div = 1'b0;
    s3_side_nxt.neg_q   = s2_dout_r[RB-1];
    s3_side_nxt.pressed = s2_bvalid_r && pr;
    s3_side_nxt.base    = s2_omin_r;
    if (!s2_bvalid_r) begin
      s3_side_nxt.base = '0;
    end else if (s2_op_r == cbe_pkg::OP_BUTTON || s2_op_r == cbe_pkg::OP_HAT) begin
      s3_side_nxt.base = pr ? s2_omax_r : s2_omin_r;
    end else if (s2_op_r == cbe_pkg::OP_AXIS && s2_present_r) begin
      s3_side_nxt.use_div = !s2_span_zero_r;
    end
  end

  logic               s3_v_r;
  cbe_pkg::cbe_side_t s3_side_r;
  logic [MB-1:0]      s3_abs_d_r;
  logic [SB-1:0]      s3_abs_dout_r;
  logic [MB-1:0]      s3_abs_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r     <= s3_side_nxt;
      s3_abs_d_r    <= s2_d_r[DB-1] ? d_neg[MB-1:0] : s2_d_r[MB-1:0];
      s3_abs_dout_r <= s2_dout_r[RB-1] ? dout_neg[SB-1:0] : s2_dout_r[SB-1:0];
      s3_abs_span_r <= s2_abs_span_r;
    end
  end

  // ------------------------------------------------------ stage 4: multiply
  logic               s4_v_r;
  cbe_pkg::cbe_side_t s4_side_r;
  logic [PB-1:0]      s4_prod_r;
  logic [MB-1:0]      s4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side_r <= s3_side_r;
      s4_prod_r <= PB'(s3_abs_d_r) * PB'(s3_abs_dout_r);
      s4_den_r  <= s3_abs_span_r;
    end
  end

  // ------------------------------------------------------------- divider
  logic               dv_valid;
  logic [QB-1:0]      dv_quo;
  cbe_pkg::cbe_side_t dv_side;

  cbe_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s4_v_r),
    .num       (s4_prod_r),
    .den       (s4_den_r),
    .in_side   (s4_side_r),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_side  (dv_side)
  );

  // ------------------------------------------- output: offset and saturate
  logic signed [RB-1:0] q_ext;
  logic signed [RB-1:0] sum;
  logic signed [RB-1:0] res;

  always_comb begin
    q_ext = signed'({{(RB-QB){1'b0}}, dv_quo});
    sum   = dv_side.neg_q ? (dv_side.base - q_ext) : (dv_side.base + q_ext);
    res   = dv_side.base;
    if (dv_side.use_div) begin
      res = sum;
      if (res < low_ext) begin
        res = low_ext;
      end
      if (res > high_ext) begin
        res = high_ext;
      end
    end
  end

  logic          out_pressed_r;
  logic [OB-1:0] out_axis_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pressed_r <= dv_side.pressed;
      out_axis_r    <= res[OB-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(cbe_pkg::OUT_TDATA_BITS-OB-1){1'b0}}, out_axis_r, out_pressed_r};

endmodule
